[rtl/assert_macros.svh]
// Assertion helpers shared by the parser front, queue and result modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/wrhp_pkg.sv]
// ----------------------------------------------------------------------------
// wrhp_pkg
// Shared types and constants of the WAV RIFF header parser.
// ----------------------------------------------------------------------------
package wrhp_pkg;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_LEN = 32'd16;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int TDATA_W = 144;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NOT_RIFF   = 3'd0,
    ERR_NO_WAVE    = 3'd1,
    ERR_FMT_LEN    = 3'd2,
    ERR_BYTE_RATE  = 3'd3,
    ERR_ALIGN      = 3'd4,
    ERR_DATA_FIRST = 3'd5,
    ERR_ZERO_LEN   = 3'd6
  } err_e;

  // Work items passed from the parser front to the result back end.
  typedef enum logic [2:0] {
    IT_PAYLOAD   = 3'd0,
    IT_HEADER    = 3'd1,
    IT_ERROR     = 3'd2,
    IT_FMT_CHECK = 3'd3,
    IT_RESTART   = 3'd4
  } item_e;

  typedef struct packed {
    item_e       kind;
    logic [7:0]  data;
    logic        last;
    err_e        err;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] length;
    logic [31:0] byte_rate;
    logic [31:0] rate_product;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic        last;
    logic [7:0]  payload;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] length;
    err_e        err;
  } result_t;

endpackage

[rtl/wrhp_front.sv]
// ----------------------------------------------------------------------------
// wrhp_front
// Byte-level parser: walks the RIFF/WAVE structure and queues work items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrhp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          byte_i,
  input  logic                restart_i,
  input  logic                full_i,
  output logic                push_o,
  output wrhp_pkg::item_t     item_o
);

  localparam int POS_W = $clog2(int'(wrhp_pkg::FMT_LEN));

  typedef enum logic [3:0] {
    PH_RIFF_ID, PH_RIFF_LEN, PH_WAVE, PH_CHUNK_HDR, PH_FMT,
    PH_SKIP, PH_DATA, PH_DONE, PH_ERROR
  } phase_e;

  phase_e             phase_q, phase_d, phase_cur;
  logic [POS_W-1:0]   pos_q, pos_d, pos_cur;
  logic               seen_q, seen_d, seen_cur;
  logic [31:0]        id_q, id_d, id_shifted;
  logic [31:0]        len_q, len_d, len_shifted;
  logic [31:0]        rem_q, rem_d;
  logic [15:0]        tag_q, tag_d;
  logic [15:0]        chan_q, chan_d;
  logic [31:0]        rate_q, rate_d;
  logic [31:0]        brate_q, brate_d;
  logic [15:0]        align_q, align_d;
  logic [15:0]        bits_q, bits_d;
  logic [31:0]        prod_q, prod_d;
  logic [31:0]        prod_full;
  logic               acc;

  assign ready_o    = !full_i;
  assign acc        = valid_i && ready_o;
  assign id_shifted  = {id_q[23:0], byte_i};
  assign len_shifted = {byte_i, len_q[31:8]};
  assign prod_full   = {16'd0, align_q} * rate_q;

  always_comb begin
    phase_cur = restart_i ? PH_RIFF_ID : phase_q;
    pos_cur   = restart_i ? '0 : pos_q;
    seen_cur  = restart_i ? 1'b0 : seen_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    seen_d    = seen_q;
    id_d      = id_q;
    len_d     = len_q;
    rem_d     = rem_q;
    tag_d     = tag_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    brate_d   = brate_q;
    align_d   = align_q;
    bits_d    = bits_q;
    prod_d    = prod_q;
    push_o    = 1'b0;
    item_o    = '0;
    item_o.kind = wrhp_pkg::IT_RESTART;
    if (acc) begin
      phase_d = phase_cur;
      pos_d   = pos_cur + POS_W'(1);
      seen_d  = seen_cur;
      push_o  = restart_i;
      case (phase_cur)
        PH_RIFF_ID, PH_WAVE: begin
          id_d = id_shifted;
          if (pos_cur == POS_W'(3)) begin
            pos_d = '0;
            if (phase_cur == PH_RIFF_ID) begin
              if (id_shifted != wrhp_pkg::ID_RIFF) begin
                phase_d     = PH_ERROR;
                push_o      = 1'b1;
                item_o.kind = wrhp_pkg::IT_ERROR;
                item_o.err  = wrhp_pkg::ERR_NOT_RIFF;
              end else begin
                phase_d = PH_RIFF_LEN;
              end
            end else begin
              if (id_shifted != wrhp_pkg::ID_WAVE) begin
                phase_d     = PH_ERROR;
                push_o      = 1'b1;
                item_o.kind = wrhp_pkg::IT_ERROR;
                item_o.err  = wrhp_pkg::ERR_NO_WAVE;
              end else begin
                phase_d = PH_CHUNK_HDR;
              end
            end
          end
        end
        PH_RIFF_LEN: begin
          if (pos_cur == POS_W'(3)) begin
            pos_d   = '0;
            phase_d = PH_WAVE;
          end
        end
        PH_CHUNK_HDR: begin
          if (!pos_cur[2]) begin
            id_d = id_shifted;
          end else begin
            len_d = len_shifted;
          end
          if (pos_cur == POS_W'(7)) begin
            pos_d = '0;
            rem_d = len_shifted;
            if (len_shifted == 32'd0) begin
              phase_d     = PH_ERROR;
              push_o      = 1'b1;
              item_o.kind = wrhp_pkg::IT_ERROR;
              item_o.err  = wrhp_pkg::ERR_ZERO_LEN;
            end else if (id_q == wrhp_pkg::ID_FMT) begin
              if (len_shifted != wrhp_pkg::FMT_LEN) begin
                phase_d     = PH_ERROR;
                push_o      = 1'b1;
                item_o.kind = wrhp_pkg::IT_ERROR;
                item_o.err  = wrhp_pkg::ERR_FMT_LEN;
              end else begin
                phase_d = PH_FMT;
              end
            end else if (id_q == wrhp_pkg::ID_DATA) begin
              push_o = 1'b1;
              if (!seen_cur) begin
                phase_d     = PH_ERROR;
                item_o.kind = wrhp_pkg::IT_ERROR;
                item_o.err  = wrhp_pkg::ERR_DATA_FIRST;
              end else begin
                phase_d           = PH_DATA;
                item_o.kind       = wrhp_pkg::IT_HEADER;
                item_o.format_tag = tag_q;
                item_o.channels   = chan_q;
                item_o.rate       = rate_q;
                item_o.align      = align_q;
                item_o.bits       = bits_q;
                item_o.length     = len_shifted;
              end
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          case (pos_cur)
            POS_W'(0):  tag_d = {8'd0, byte_i};
            POS_W'(1):  tag_d = {byte_i, tag_q[7:0]};
            POS_W'(2):  chan_d = {8'd0, byte_i};
            POS_W'(3):  chan_d = {byte_i, chan_q[7:0]};
            POS_W'(4), POS_W'(5), POS_W'(6), POS_W'(7):
              rate_d = {byte_i, rate_q[31:8]};
            POS_W'(8), POS_W'(9), POS_W'(10), POS_W'(11):
              brate_d = {byte_i, brate_q[31:8]};
            POS_W'(12): align_d = {8'd0, byte_i};
            POS_W'(13): align_d = {byte_i, align_q[7:0]};
            POS_W'(14): begin
              bits_d = {8'd0, byte_i};
              prod_d = prod_full;
            end
            default: begin
              bits_d              = {byte_i, bits_q[7:0]};
              pos_d               = '0;
              seen_d              = 1'b1;
              phase_d             = PH_CHUNK_HDR;
              push_o              = 1'b1;
              item_o.kind         = wrhp_pkg::IT_FMT_CHECK;
              item_o.channels     = chan_q;
              item_o.align        = align_q;
              item_o.bits         = {byte_i, bits_q[7:0]};
              item_o.byte_rate    = brate_q;
              item_o.rate_product = prod_q;
            end
          endcase
        end
        PH_SKIP: begin
          pos_d = pos_q;
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            phase_d = PH_CHUNK_HDR;
            pos_d   = '0;
          end
        end
        PH_DATA: begin
          pos_d       = pos_q;
          rem_d       = rem_q - 32'd1;
          push_o      = 1'b1;
          item_o.kind = wrhp_pkg::IT_PAYLOAD;
          item_o.data = byte_i;
          item_o.last = (rem_q == 32'd1);
          if (rem_q == 32'd1) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          pos_d = pos_cur;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF_ID;
      pos_q   <= '0;
      seen_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    len_q   <= len_d;
    rem_q   <= rem_d;
    tag_q   <= tag_d;
    chan_q  <= chan_d;
    rate_q  <= rate_d;
    brate_q <= brate_d;
    align_q <= align_d;
    bits_q  <= bits_d;
    prod_q  <= prod_d;
  end

  `ASSERT_CLK(a_push_on_accept, clk_i, rst_ni, push_o |-> (valid_i && !full_i), "push without accepted byte")
  `ASSERT_NEVER(a_quiet_when_done, clk_i, rst_ni, acc && !restart_i && push_o && (phase_q == PH_DONE || phase_q == PH_ERROR), "item after end of parse")

endmodule

[rtl/wrhp_fifo.sv]
// ----------------------------------------------------------------------------
// wrhp_fifo
// Short queue of work items between parser front and result back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrhp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wrhp_pkg::item_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output wrhp_pkg::item_t  item_o,
  output logic             empty_o
);

  localparam int PW = wrhp_pkg::FIFO_PTR_W;
  localparam int CW = wrhp_pkg::FIFO_CNT_W;

  wrhp_pkg::item_t mem_q [wrhp_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(wrhp_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(wrhp_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(wrhp_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, cnt_q <= CW'(wrhp_pkg::FIFO_DEPTH), "queue count out of range")

endmodule

[rtl/wrhp_back.sv]
// ----------------------------------------------------------------------------
// wrhp_back
// Result stage: runs the fmt checks, drops items after an error, and holds
// the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrhp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  wrhp_pkg::item_t    item_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output wrhp_pkg::result_t  result_o
);

  wrhp_pkg::result_t res_q, res_d, res_new;
  logic              valid_q, valid_d;
  logic              dead_q, dead_d;
  logic [31:0]       chan_bits;
  logic [31:0]       min_align;

  assign pop_o     = !empty_i && (!valid_q || ready_i);
  assign chan_bits = {16'd0, item_i.channels} * {16'd0, item_i.bits};
  assign min_align = chan_bits >> 3;
  assign valid_o   = valid_q;
  assign result_o  = res_q;

  always_comb begin
    res_new = '0;
    res_d   = res_q;
    valid_d = valid_q && !ready_i;
    dead_d  = dead_q;
    if (pop_o) begin
      case (item_i.kind)
        wrhp_pkg::IT_RESTART: begin
          dead_d = 1'b0;
        end
        wrhp_pkg::IT_FMT_CHECK: begin
          if (!dead_q) begin
            res_new.kind = wrhp_pkg::KIND_ERROR;
            if (item_i.rate_product != item_i.byte_rate) begin
              res_new.err = wrhp_pkg::ERR_BYTE_RATE;
              res_d       = res_new;
              valid_d     = 1'b1;
              dead_d      = 1'b1;
            end else if ({16'd0, item_i.align} < min_align) begin
              res_new.err = wrhp_pkg::ERR_ALIGN;
              res_d       = res_new;
              valid_d     = 1'b1;
              dead_d      = 1'b1;
            end
          end
        end
        wrhp_pkg::IT_ERROR: begin
          if (!dead_q) begin
            res_new.kind = wrhp_pkg::KIND_ERROR;
            res_new.err  = item_i.err;
            res_d        = res_new;
            valid_d      = 1'b1;
            dead_d       = 1'b1;
          end
        end
        wrhp_pkg::IT_HEADER: begin
          if (!dead_q) begin
            res_new.kind       = wrhp_pkg::KIND_HEADER;
            res_new.format_tag = item_i.format_tag;
            res_new.channels   = item_i.channels;
            res_new.rate       = item_i.rate;
            res_new.align      = item_i.align;
            res_new.bits       = item_i.bits;
            res_new.length     = item_i.length;
            res_d              = res_new;
            valid_d            = 1'b1;
          end
        end
        wrhp_pkg::IT_PAYLOAD: begin
          if (!dead_q) begin
            res_new.kind    = wrhp_pkg::KIND_PAYLOAD;
            res_new.payload = item_i.data;
            res_new.last    = item_i.last;
            res_d           = res_new;
            valid_d         = 1'b1;
          end
        end
        default: begin
          dead_d = dead_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dead_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dead_q  <= dead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  `ASSERT_CLK(a_restart_revives, clk_i, rst_ni, (pop_o && item_i.kind == wrhp_pkg::IT_RESTART) |=> !dead_q, "restart did not clear error hold")
  `ASSERT_CLK(a_dead_is_silent, clk_i, rst_ni, (dead_q && pop_o && item_i.kind != wrhp_pkg::IT_RESTART) |=> !valid_q, "result after error")

endmodule

[rtl/wav_riff_header_parser_top.sv]
// Results pass the item queue and then the output register. Throughput: one
// byte per cycle on s_axis while the queue is not full, one result per cycle
// on m_axis while m_axis_tready is high. A two-entry item queue sits between
// parser and output register; a restart byte takes one slot, gives no result.
// Reset: rst_ni low clears parser phase, queue and output valid at once.
// ----------------------------------------------------------------------------
// wav_riff_header_parser_top
// WAV RIFF header parser: byte stream in, header, payload and error out.
// ----------------------------------------------------------------------------
module wav_riff_header_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] stream_byte
  input  logic [0:0]                    s_axis_tuser,  // [0] restart
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [23:8] audio_format, [39:24] channel_count,
  // [71:40] sample_rate_hz, [87:72] block_align_bytes, [103:88] sample_bits,
  // [135:104] data_length, [138:136] error_code, [143:139] zero
  output logic [wrhp_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,  // last_payload
  output logic [1:0]                    m_axis_tuser   // [1:0] result_kind
);

  wrhp_pkg::item_t   push_item, head_item;
  wrhp_pkg::result_t result;
  logic              push, pop, full, empty;

  wrhp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .byte_i    (s_axis_tdata),
    .restart_i (s_axis_tuser[0]),
    .full_i    (full),
    .push_o    (push),
    .item_o    (push_item)
  );

  wrhp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  wrhp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .item_i   (head_item),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tdata = {5'd0, result.err, result.length, result.bits, result.align,
                         result.rate, result.channels, result.format_tag,
                         result.payload};
  assign m_axis_tlast = result.last;
  assign m_axis_tuser = result.kind;

endmodule
